[rtl/core/pefg_pkg.sv]
// ----------------------------------------------------------------------------
// pefg_pkg
// Types, codes and constants shared by the pulse envelope frame generator.
// ----------------------------------------------------------------------------
`default_nettype none

package pefg_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 35;
	localparam int NUM_PAIRS  = 16;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_AMPLITUDES = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_DURATIONS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TREMOLO_DEPTHS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_SCALES    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RISE_STEPS      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PLATEAU_STEPS   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TREMOLO_QUARTER = 3'd6;

	localparam logic OP_START   = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	// amplitude and duration limits
	localparam logic signed [10:0] RAMP_AMP_MIN    = 11'sd6;
	localparam logic signed [10:0] RAMP_AMP_MAX    = 11'sd249;
	localparam logic signed [10:0] PLATEAU_AMP_MIN = 11'sd16;
	localparam logic signed [10:0] PLATEAU_AMP_MAX = 11'sd239;
	localparam logic signed [10:0] DUR_MAX         = 11'sd239;
	localparam logic signed [10:0] DUR_MIN         = 11'sd16;

	// floor(x/100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x below 43690
	localparam int unsigned RECIP_100   = 5243;
	localparam int unsigned RECIP_SHIFT = 19;
	localparam int unsigned STEP_NUM    = 240;
	localparam logic [7:0]  SLOT0_SCALE = 8'd100;
	localparam int          STEP_W      = 20;

	typedef enum logic [1:0] {
		STAGE_RISE    = 2'd0,
		STAGE_PLATEAU = 2'd1,
		STAGE_FALL    = 2'd2,
		STAGE_IDLE    = 2'd3
	} stage_t;

	typedef struct packed {
		logic              operation;
		logic signed [7:0] duration_offset;
	} in_item_t;

	typedef struct packed {
		logic [3:0] pair_index;
		logic [7:0] amplitude;
		logic [7:0] duration;
		logic [1:0] stage;
		logic       last_in_frame;
		logic       note_done;
	} out_item_t;

	typedef struct packed {
		logic [15:0] base_amplitudes;
		logic [15:0] base_durations;
		logic [15:0] tremolo_depths;
		logic [34:0] extra_scales;
		logic [7:0]  rise_steps;
		logic [9:0]  plateau_steps;
		logic [7:0]  tremolo_quarter;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       fire;
		logic       pos_clear;
		logic       pos_step;
		logic [3:0] idx;
		stage_t     stage;
		logic       final_frame;
	} cmd_t;

	function automatic logic [7:0] clamp_amp(input logic signed [10:0] v,
			input logic signed [10:0] lo, input logic signed [10:0] hi);
		logic signed [10:0] r;
		r = v;
		if (v > hi) begin
			r = hi;
		end else if (v < lo) begin
			r = lo;
		end
		return r[7:0];
	endfunction

endpackage

`default_nettype wire

[rtl/core/pefg_stream_if.sv]
// ----------------------------------------------------------------------------
// pefg_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pefg_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/pefg_cfg_regs.sv]
// ----------------------------------------------------------------------------
// pefg_cfg_regs
// Configuration register file written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module pefg_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire logic [pefg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pefg_pkg::CFG_DATA_W-1:0] cfg_data,
	output pefg_pkg::cfg_t                      cfg
);
	import pefg_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_amplitudes <= 16'd32896;
			cfg_q.base_durations  <= 16'd0;
			cfg_q.tremolo_depths  <= 16'd0;
			cfg_q.extra_scales    <= 35'd0;
			cfg_q.rise_steps      <= 8'd1;
			cfg_q.plateau_steps   <= 10'd0;
			cfg_q.tremolo_quarter <= 8'd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_BASE_AMPLITUDES: cfg_q.base_amplitudes <= cfg_data[15:0];
				CFG_BASE_DURATIONS:  cfg_q.base_durations  <= cfg_data[15:0];
				CFG_TREMOLO_DEPTHS:  cfg_q.tremolo_depths  <= cfg_data[15:0];
				CFG_EXTRA_SCALES:    cfg_q.extra_scales    <= cfg_data[34:0];
				CFG_RISE_STEPS:      cfg_q.rise_steps      <= cfg_data[7:0];
				CFG_PLATEAU_STEPS:   cfg_q.plateau_steps   <= cfg_data[9:0];
				CFG_TREMOLO_QUARTER: cfg_q.tremolo_quarter <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/core/pefg_ctrl.sv]
// ----------------------------------------------------------------------------
// pefg_ctrl
// Note sequencer: stage and frame counting, pair counter, result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module pefg_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  pefg_pkg::cfg_t    cfg,
	input  wire logic         item_valid,
	input  wire logic         item_op,
	output logic              item_ready,
	output logic              result_valid,
	input  wire logic         result_ready,
	output pefg_pkg::cmd_t    cmd
);
	import pefg_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	state_t     state_q;
	stage_t     stage_q;
	logic [9:0] frames_q;
	logic [3:0] cnt_q;
	logic       ovalid_q;

	logic       accept;
	logic       fire;
	logic       frame_end;
	logic [9:0] frames_dec;
	stage_t     nstage;
	logic [9:0] nframes;
	logic       nclear;
	stage_t     start_stage;
	logic [9:0] start_frames;

	// stage that follows the current frame, empty stages skipped
	always_comb begin
		frames_dec = frames_q - 10'd1;
		nstage     = stage_q;
		nframes    = frames_dec;
		nclear     = 1'b0;
		if (frames_dec == 10'd0) begin
			unique case (stage_q)
				STAGE_RISE: begin
					nclear = 1'b1;
					if (cfg.plateau_steps != 10'd0) begin
						nstage  = STAGE_PLATEAU;
						nframes = cfg.plateau_steps;
					end else if (cfg.rise_steps > 8'd1) begin
						nstage  = STAGE_FALL;
						nframes = {2'b00, cfg.rise_steps - 8'd1};
					end else begin
						nstage  = STAGE_IDLE;
						nframes = 10'd0;
					end
				end
				STAGE_PLATEAU: begin
					if (cfg.rise_steps > 8'd1) begin
						nstage  = STAGE_FALL;
						nframes = {2'b00, cfg.rise_steps - 8'd1};
					end else begin
						nstage  = STAGE_IDLE;
						nframes = 10'd0;
					end
				end
				default: begin
					nstage  = STAGE_IDLE;
					nframes = 10'd0;
				end
			endcase
		end
	end

	always_comb begin
		if (cfg.rise_steps != 8'd0) begin
			start_stage  = STAGE_RISE;
			start_frames = {2'b00, cfg.rise_steps};
		end else if (cfg.plateau_steps != 10'd0) begin
			start_stage  = STAGE_PLATEAU;
			start_frames = cfg.plateau_steps;
		end else begin
			start_stage  = STAGE_IDLE;
			start_frames = 10'd0;
		end
	end

	assign item_ready   = (state_q == S_IDLE);
	assign accept       = item_valid && item_ready;
	assign fire         = (state_q == S_RUN) && (!ovalid_q || result_ready);
	assign frame_end    = fire && (cnt_q == 4'hF);
	assign result_valid = ovalid_q;

	always_comb begin
		cmd.load        = accept && (item_op == OP_START);
		cmd.fire        = fire;
		cmd.pos_clear   = cmd.load || (frame_end && nclear);
		cmd.pos_step    = frame_end && (stage_q == STAGE_PLATEAU);
		cmd.idx         = cnt_q;
		cmd.stage       = stage_q;
		cmd.final_frame = (nstage == STAGE_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			stage_q  <= STAGE_IDLE;
			frames_q <= 10'd0;
			cnt_q    <= 4'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (fire) begin
				ovalid_q <= 1'b1;
			end else if (result_ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item_op == OP_START) begin
							stage_q  <= start_stage;
							frames_q <= start_frames;
						end else if (stage_q != STAGE_IDLE) begin
							state_q <= S_RUN;
							cnt_q   <= 4'd0;
						end
					end
				end
				S_RUN: begin
					if (fire) begin
						cnt_q <= cnt_q + 4'd1;
						if (cnt_q == 4'hF) begin
							state_q  <= S_IDLE;
							stage_q  <= nstage;
							frames_q <= nframes;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/pefg_datapath.sv]
// ----------------------------------------------------------------------------
// pefg_datapath
// Pair store, per-pair ramp and tremolo update unit, step rom, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pefg_datapath #(
	parameter int STEP_TABLE_DEPTH = 250
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  pefg_pkg::cfg_t          cfg,
	input  pefg_pkg::cmd_t          cmd,
	input  wire logic signed [7:0]  duration_offset,
	output pefg_pkg::out_item_t     result
);
	import pefg_pkg::*;

	localparam int IdxW = (STEP_TABLE_DEPTH > 1) ? $clog2(STEP_TABLE_DEPTH) : 1;

	logic [STEP_W-1:0] step_rom [STEP_TABLE_DEPTH];

	// rom holds step * RECIP_100, so one multiply by the scale gives the slot delta
	for (genvar g = 0; g < STEP_TABLE_DEPTH; g++) begin : g_rom
		localparam int unsigned N = g + 1;
		localparam int unsigned Q = (STEP_NUM + N) / (2 * N);
		localparam int unsigned S = ((Q == 0) ? 1 : Q) * RECIP_100;
		assign step_rom[g] = STEP_W'(S);
	end

	logic [7:0]        amp_q [NUM_PAIRS];
	logic signed [9:0] dur_q [NUM_PAIRS];
	logic signed [9:0] prev_dur_q;
	logic [9:0]        pos_q;
	out_item_t         out_q;

	logic [7:0]          rs_n;
	logic [7:0]          rs_m1;
	logic [IdxW-1:0]     rom_idx;
	logic [STEP_W-1:0]   step_val;
	logic [7:0]          scale;
	logic [27:0]         prod;
	logic [27:0]         d_full;
	logic [8:0]          delta;
	logic                raise;
	logic signed [10:0]  amp_ext;
	logic signed [10:0]  ramp_sum;
	logic [7:0]          dep;
	logic                rising;
	logic signed [10:0]  dep_ext;
	logic signed [10:0]  plat_sum;
	logic signed [10:0]  du_ext;
	logic signed [10:0]  du_t;
	logic [7:0]          new_amp;
	logic signed [9:0]   new_dur;
	logic [10:0]         pos_inc;
	logic signed [9:0]   off_ext;

	always_comb begin
		if (cfg.rise_steps == 8'd0) begin
			rs_n = 8'd1;
		end else if (cfg.rise_steps > 8'(STEP_TABLE_DEPTH)) begin
			rs_n = 8'(STEP_TABLE_DEPTH);
		end else begin
			rs_n = cfg.rise_steps;
		end
		rs_m1    = rs_n - 8'd1;
		rom_idx  = rs_m1[IdxW-1:0];
		step_val = step_rom[rom_idx];
	end

	// percent scale of the slot this pair belongs to
	always_comb begin
		case (cmd.idx[3:1])
			3'd0:    scale = SLOT0_SCALE;
			3'd1:    scale = cfg.tremolo_depths[7:0];
			3'd2:    scale = cfg.tremolo_depths[15:8];
			3'd3:    scale = {1'b0, cfg.extra_scales[6:0]};
			3'd4:    scale = {1'b0, cfg.extra_scales[13:7]};
			3'd5:    scale = {1'b0, cfg.extra_scales[20:14]};
			3'd6:    scale = {1'b0, cfg.extra_scales[27:21]};
			default: scale = {1'b0, cfg.extra_scales[34:28]};
		endcase
	end

	always_comb begin
		prod     = 28'(step_val) * 28'(scale);
		d_full   = prod >> RECIP_SHIFT;
		delta    = d_full[8:0];
		raise    = (cmd.idx[0] == 1'b0) == (cmd.stage == STAGE_RISE);
		amp_ext  = signed'({3'b000, amp_q[cmd.idx]});
		ramp_sum = raise ? amp_ext + signed'({2'b00, delta})
			: amp_ext - signed'({2'b00, delta});

		dep      = cmd.idx[0] ? cfg.tremolo_depths[15:8] : cfg.tremolo_depths[7:0];
		rising   = {1'b0, pos_q} < {2'b00, cfg.tremolo_quarter, 1'b0};
		dep_ext  = signed'({3'b000, dep});
		plat_sum = (rising == cmd.idx[0]) ? amp_ext + dep_ext : amp_ext - dep_ext;
		du_ext   = {dur_q[cmd.idx][9], dur_q[cmd.idx]};
		if (rising) begin
			du_t = du_ext + dep_ext;
			if (du_t > DUR_MAX) begin
				du_t = DUR_MAX;
			end
		end else begin
			du_t = du_ext - dep_ext;
			if (du_t < DUR_MIN) begin
				du_t = DUR_MIN;
			end
		end

		if (cmd.stage == STAGE_PLATEAU) begin
			new_amp = clamp_amp(plat_sum, PLATEAU_AMP_MIN, PLATEAU_AMP_MAX);
			new_dur = du_t[9:0];
		end else begin
			new_amp = clamp_amp(ramp_sum, RAMP_AMP_MIN, RAMP_AMP_MAX);
			new_dur = dur_q[cmd.idx];
		end

		pos_inc = {1'b0, pos_q} + 11'd1;
		off_ext = {{2{duration_offset[7]}}, duration_offset};
	end

	// tremolo position wraps at 4T
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 10'd0;
		end else if (cmd.pos_clear) begin
			pos_q <= 10'd0;
		end else if (cmd.pos_step) begin
			if (pos_inc >= {1'b0, cfg.tremolo_quarter, 2'b00}) begin
				pos_q <= 10'd0;
			end else begin
				pos_q <= pos_inc[9:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < NUM_PAIRS; i++) begin
				if (i % 2 == 1) begin
					amp_q[i] <= cfg.base_amplitudes[15:8];
					dur_q[i] <= signed'({2'b00, cfg.base_durations[15:8]}) + off_ext;
				end else begin
					amp_q[i] <= cfg.base_amplitudes[7:0];
					dur_q[i] <= signed'({2'b00, cfg.base_durations[7:0]}) + off_ext;
				end
			end
		end else if (cmd.fire) begin
			amp_q[cmd.idx] <= new_amp;
			dur_q[cmd.idx] <= new_dur;
		end
		if (cmd.fire) begin
			prev_dur_q          <= new_dur;
			out_q.pair_index    <= cmd.idx;
			out_q.amplitude     <= new_amp;
			// pairs above one report the duration of the pair before them
			out_q.duration      <= (cmd.idx < 4'd2) ? new_dur[7:0] : prev_dur_q[7:0];
			out_q.stage         <= cmd.stage;
			out_q.last_in_frame <= (cmd.idx == 4'hF);
			out_q.note_done     <= (cmd.idx == 4'hF) && cmd.final_frame;
		end
	end

	assign result = out_q;

endmodule

`default_nettype wire

[rtl/core/pulse_envelope_frame_generator.sv]
// ----------------------------------------------------------------------------
// pulse_envelope_frame_generator
// Envelope generator producing frames of sixteen amplitude/duration pairs.
// ----------------------------------------------------------------------------
// Usage:
//  item carries operation and duration_offset. A start transaction loads the
//  sixteen pairs from the configuration registers and gives no results. An
//  advance transaction updates the pairs of the running note and emits one
//  frame on result: sixteen transactions, pair 0 first, the last one flagged
//  with last_in_frame (and note_done on the note's final frame).
//  An advance while no note runs gives no results.
//  The pairs go through one shared update unit, one pair per cycle while
//  result does not stall; item ready rises again as pair 15 enters the result
//  register. The first result is registered once the controller has entered
//  its run state. A stalled receiver holds the result register and freezes
//  the pair counter.
//  Configuration must be written through cfg_write/cfg_index/cfg_data only
//  while idle, by the user; the block itself does not enforce it. Reset
//  returns the registers to their defaults and leaves no note running; the
//  pair store holds nothing until the first start.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_envelope_frame_generator #(
	parameter int STEP_TABLE_DEPTH = 250
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire logic [pefg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pefg_pkg::CFG_DATA_W-1:0] cfg_data,
	pefg_stream_if.sink                          item,
	pefg_stream_if.source                        result
);
	import pefg_pkg::*;

	cfg_t      cfg;
	cmd_t      cmd;
	in_item_t  item_data;
	out_item_t result_data;

	assign item_data   = item.data;
	assign result.data = result_data;

	pefg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pefg_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.item_valid   (item.valid),
		.item_op      (item_data.operation),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.cmd          (cmd)
	);

	pefg_datapath #(
		.STEP_TABLE_DEPTH (STEP_TABLE_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.duration_offset (item_data.duration_offset),
		.result          (result_data)
	);

	// no new item is taken while a frame is still being emitted
	a_busy_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result_data.last_in_frame |-> !item.ready)
		else $error("item accepted in the middle of a frame");

	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result_data.note_done |->
			result_data.last_in_frame && (result_data.pair_index == 4'hF))
		else $error("note_done outside the last pair of a frame");

	// a pair that is taken while the next one fires is followed by the next index
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && !result_data.last_in_frame
			&& cmd.fire |=> result_data.pair_index == $past(result_data.pair_index) + 4'd1)
		else $error("pair index out of order");

endmodule

`default_nettype wire

[bench/pulse_envelope_frame_generator_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pulse_envelope_frame_generator_test
// Self-checking bench for the envelope frame generator. Start and advance
// transactions are sent with random gaps while the result side stalls at
// random. A cycle-free model of the note (rise, tremolo plateau, fall) runs
// alongside and every pair of every frame is compared field by field.
// ----------------------------------------------------------------------------

module pulse_envelope_frame_generator_test;

	import pefg_pkg::*;

	localparam int          HALF_PERIOD  = 6;
	localparam int          RESET_CYCLES = 7;
	localparam int          STEP_DEPTH   = 250;
	localparam int          PERCENT      = 100;
	localparam int          STEP_SPAN    = 240;
	localparam int          RANDOM_ITEMS = 100;
	localparam int          NOTE_CAP     = 20;
	localparam int          TAIL_CYCLES  = 40;
	localparam int unsigned DRAIN_LIMIT  = 200000;
	localparam longint      RUN_LIMIT_NS = 64'd12_000_000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pefg_stream_if #(.payload_t(in_item_t))  item ();
	pefg_stream_if #(.payload_t(out_item_t)) result ();

	pulse_envelope_frame_generator #(
		.STEP_TABLE_DEPTH(STEP_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item(item),
		.result(result)
	);

	// note model state
	cfg_t              regs;
	logic [7:0]        amp_st [NUM_PAIRS];
	logic signed [9:0] dur_st [NUM_PAIRS];
	stage_t            stage_st;
	int unsigned       frames_st;
	int unsigned       trem_pos;

	in_item_t    items_to_send [$];
	out_item_t   pairs_due [$];
	bit          item_took;
	int unsigned send_gap;
	int unsigned send_calm;
	int unsigned stall_left;
	int unsigned ready_calm;

	int mismatches;
	int pairs_checked;
	int frames_predicted;
	int starts_taken;
	int writes_done;
	int phases_run;
	int random_items;

	always begin
		clk = 1'b0;
		#(HALF_PERIOD);
		clk = 1'b1;
		#(HALF_PERIOD);
	end

	task automatic report_mismatch(input string what, input int got_v, input int want_v);
		mismatches++;
		$display("mismatch: %s at result %0d, got %0d, wanted %0d",
			what, pairs_checked, got_v, want_v);
	endtask

	function automatic int limit_int(input int v, input int lo, input int hi);
		if (v > hi) begin
			return hi;
		end
		if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	function automatic int ramp_step();
		int n;
		int q;
		n = regs.rise_steps;
		if (n < 1) begin
			n = 1;
		end
		if (n > STEP_DEPTH) begin
			n = STEP_DEPTH;
		end
		q = (STEP_SPAN + n) / (2 * n);
		return (q != 0) ? q : 1;
	endfunction

	function automatic int slot_percent(input int k);
		if (k == 1) begin
			return regs.tremolo_depths[7:0];
		end
		if (k == 2) begin
			return regs.tremolo_depths[15:8];
		end
		return (regs.extra_scales >> (7 * (k - 3))) & 35'h7f;
	endfunction

	// skip stages that have no frames left
	task automatic next_stage();
		while (stage_st != STAGE_IDLE && frames_st == 0) begin
			case (stage_st)
				STAGE_RISE: begin
					stage_st  = STAGE_PLATEAU;
					frames_st = regs.plateau_steps;
					trem_pos  = 0;
				end
				STAGE_PLATEAU: begin
					stage_st  = STAGE_FALL;
					frames_st = (regs.rise_steps != 0) ? regs.rise_steps - 1 : 0;
				end
				default: begin
					stage_st = STAGE_IDLE;
				end
			endcase
		end
	endtask

	task automatic ramp_frame(input bit up);
		int  i;
		int  step;
		int  d;
		int  a;
		bit  lift;
		step = ramp_step();
		for (i = 0; i < NUM_PAIRS; i++) begin
			d    = ((i / 2) == 0) ? step : step * slot_percent(i / 2) / PERCENT;
			lift = ((i % 2) == 0) == up;
			a    = int'(amp_st[i]) + (lift ? d : -d);
			amp_st[i] = 8'(limit_int(a, int'(RAMP_AMP_MIN), int'(RAMP_AMP_MAX)));
		end
	endtask

	task automatic plateau_frame();
		int i;
		int half;
		int dep;
		int a;
		int du;
		bit odd;
		bit rising;
		half   = 2 * regs.tremolo_quarter;
		rising = trem_pos < half;
		for (i = 0; i < NUM_PAIRS; i++) begin
			odd = (i % 2) == 1;
			dep = odd ? regs.tremolo_depths[15:8] : regs.tremolo_depths[7:0];
			a   = int'(amp_st[i]);
			du  = dur_st[i];
			if (rising) begin
				a  += odd ? dep : -dep;
				du += dep;
				if (du > int'(DUR_MAX)) begin
					du = DUR_MAX;
				end
			end else begin
				a  += odd ? -dep : dep;
				du -= dep;
				if (du < int'(DUR_MIN)) begin
					du = DUR_MIN;
				end
			end
			amp_st[i] = 8'(limit_int(a, int'(PLATEAU_AMP_MIN), int'(PLATEAU_AMP_MAX)));
			dur_st[i] = 10'(du);
		end
		trem_pos++;
		if (trem_pos >= 2 * half) begin
			trem_pos = 0;
		end
	endtask

	task automatic predict_item(input in_item_t it);
		int        i;
		int        off;
		int        src;
		stage_t    was;
		bit        done;
		out_item_t p;
		if (it.operation == OP_START) begin
			off = $signed(it.duration_offset);
			for (i = 0; i < NUM_PAIRS; i++) begin
				if ((i % 2) == 1) begin
					amp_st[i] = regs.base_amplitudes[15:8];
					dur_st[i] = 10'(int'(regs.base_durations[15:8]) + off);
				end else begin
					amp_st[i] = regs.base_amplitudes[7:0];
					dur_st[i] = 10'(int'(regs.base_durations[7:0]) + off);
				end
			end
			stage_st  = STAGE_RISE;
			frames_st = regs.rise_steps;
			trem_pos  = 0;
			starts_taken++;
			next_stage();
		end else if (stage_st != STAGE_IDLE) begin
			was = stage_st;
			case (was)
				STAGE_RISE:    ramp_frame(1'b1);
				STAGE_PLATEAU: plateau_frame();
				default:       ramp_frame(1'b0);
			endcase
			frames_st--;
			next_stage();
			done = stage_st == STAGE_IDLE;
			for (i = 0; i < NUM_PAIRS; i++) begin
				src             = (i < 2) ? i : i - 1;
				p.pair_index    = 4'(i);
				p.amplitude     = amp_st[i];
				p.duration      = dur_st[src][7:0];
				p.stage         = was;
				p.last_in_frame = i == NUM_PAIRS - 1;
				p.note_done     = (i == NUM_PAIRS - 1) && done;
				pairs_due.push_back(p);
			end
			frames_predicted++;
		end
	endtask

	task automatic check_pair(input out_item_t got);
		out_item_t want;
		pairs_checked++;
		if (pairs_due.size() == 0) begin
			report_mismatch("result with nothing due, pair_index", got.pair_index, -1);
		end else begin
			want = pairs_due.pop_front();
			if (got.pair_index !== want.pair_index) begin
				report_mismatch("pair_index", got.pair_index, want.pair_index);
			end
			if (got.amplitude !== want.amplitude) begin
				report_mismatch("amplitude", got.amplitude, want.amplitude);
			end
			if (got.duration !== want.duration) begin
				report_mismatch("duration", got.duration, want.duration);
			end
			if (got.stage !== want.stage) begin
				report_mismatch("stage", got.stage, want.stage);
			end
			if (got.last_in_frame !== want.last_in_frame) begin
				report_mismatch("last_in_frame", got.last_in_frame, want.last_in_frame);
			end
			if (got.note_done !== want.note_done) begin
				report_mismatch("note_done", got.note_done, want.note_done);
			end
		end
	endtask

	task automatic reset_model();
		int i;
		regs.base_amplitudes = 16'd32896;
		regs.base_durations  = '0;
		regs.tremolo_depths  = '0;
		regs.extra_scales    = '0;
		regs.rise_steps      = 8'd1;
		regs.plateau_steps   = '0;
		regs.tremolo_quarter = 8'd1;
		for (i = 0; i < NUM_PAIRS; i++) begin
			amp_st[i] = '0;
			dur_st[i] = '0;
		end
		stage_st  = STAGE_IDLE;
		frames_st = 0;
		trem_pos  = 0;
	endtask

	// model update and result check on every rising edge
	always @(posedge clk) begin
		if (!arst_n) begin
			reset_model();
			item_took = 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_BASE_AMPLITUDES: regs.base_amplitudes = cfg_data[15:0];
					CFG_BASE_DURATIONS:  regs.base_durations  = cfg_data[15:0];
					CFG_TREMOLO_DEPTHS:  regs.tremolo_depths  = cfg_data[15:0];
					CFG_EXTRA_SCALES:    regs.extra_scales    = cfg_data[34:0];
					CFG_RISE_STEPS:      regs.rise_steps      = cfg_data[7:0];
					CFG_PLATEAU_STEPS:   regs.plateau_steps   = cfg_data[9:0];
					CFG_TREMOLO_QUARTER: regs.tremolo_quarter = cfg_data[7:0];
					default: ;
				endcase
			end
			item_took = item.valid && item.ready;
			if (item_took) begin
				predict_item(item.data);
			end
			if (result.valid && result.ready) begin
				check_pair(result.data);
			end
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 30);
	endfunction

	// item driver
	always @(negedge clk) begin
		if (!arst_n) begin
			item.valid <= 1'b0;
		end else if (item.valid && !item_took) begin
			// transaction still pending, hold valid and data
		end else if (send_calm == 0 && send_gap != 0) begin
			send_gap--;
			item.valid <= 1'b0;
		end else if (items_to_send.size() != 0) begin
			item.valid <= 1'b1;
			item.data  <= items_to_send.pop_front();
			if (send_calm != 0) begin
				send_calm--;
				send_gap = 0;
			end else if ($urandom_range(0, 39) == 0) begin
				send_calm = $urandom_range(10, 40);
			end else begin
				send_gap = pick_gap();
			end
		end else begin
			item.valid <= 1'b0;
		end
	end

	// result ready with random stalls
	always @(negedge clk) begin
		if (ready_calm != 0) begin
			ready_calm--;
			result.ready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			result.ready <= 1'b0;
		end else if ($urandom_range(0, 149) == 0) begin
			ready_calm = $urandom_range(30, 120);
			result.ready <= 1'b1;
		end else begin
			stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
			result.ready <= stall_left == 0;
			if (stall_left != 0) begin
				stall_left--;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		writes_done++;
	endtask

	task automatic queue_item(input logic op, input int off);
		in_item_t it;
		it.operation       = op;
		it.duration_offset = 8'(off);
		items_to_send.push_back(it);
	endtask

	task automatic queue_advances(input int n);
		int i;
		for (i = 0; i < n; i++) begin
			queue_item(OP_ADVANCE, $urandom_range(0, 255));
		end
	endtask

	// wait until every transaction is sent and every frame received
	// checked at the rising edge, where queue and valid are settled
	task automatic drain_block();
		int unsigned waited;
		waited = 0;
		while ((items_to_send.size() != 0 || item.valid || pairs_due.size() != 0)
				&& waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(negedge clk);
		phases_run++;
	endtask

	function automatic logic [7:0] pick_rise();
		case ($urandom_range(0, 11))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'd250;
			3:       return 8'($urandom_range(1, 255));
			default: return 8'($urandom_range(1, 4));
		endcase
	endfunction

	function automatic logic [9:0] pick_plateau();
		case ($urandom_range(0, 9))
			0:       return 10'd1023;
			1:       return 10'($urandom_range(0, 1023));
			default: return 10'($urandom_range(0, 6));
		endcase
	endfunction

	function automatic logic [7:0] pick_quarter();
		case ($urandom_range(0, 9))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'($urandom_range(1, 255));
			default: return 8'($urandom_range(1, 3));
		endcase
	endfunction

	task automatic random_phase();
		logic [7:0]  rise;
		logic [9:0]  plat;
		logic [63:0] wide;
		int          notes;
		int          n;
		int          frames;
		rise = pick_rise();
		plat = pick_plateau();
		wide = {$urandom, $urandom};
		write_reg(CFG_BASE_AMPLITUDES, CFG_DATA_W'($urandom_range(0, 65535)));
		write_reg(CFG_BASE_DURATIONS, CFG_DATA_W'($urandom_range(0, 65535)));
		write_reg(CFG_TREMOLO_DEPTHS, CFG_DATA_W'($urandom_range(0, 65535)));
		write_reg(CFG_EXTRA_SCALES, wide[CFG_DATA_W-1:0]);
		write_reg(CFG_RISE_STEPS, CFG_DATA_W'(rise));
		write_reg(CFG_PLATEAU_STEPS, CFG_DATA_W'(plat));
		write_reg(CFG_TREMOLO_QUARTER, CFG_DATA_W'(pick_quarter()));
		notes = $urandom_range(1, 3);
		for (n = 0; n < notes; n++) begin
			// stray advance, ignored when no note runs
			if ($urandom_range(0, 7) == 0) begin
				queue_advances(1);
			end
			frames = int'(rise) + int'(plat) + ((rise != 0) ? int'(rise) - 1 : 0);
			if (frames > NOTE_CAP) begin
				frames = NOTE_CAP;
			end
			// broken note, cut short by the next start
			if (frames > 0 && $urandom_range(0, 5) == 0) begin
				frames = $urandom_range(0, frames - 1);
			end
			queue_item(OP_START, $urandom_range(0, 255));
			queue_advances(frames);
			random_items += frames + 1;
			if ($urandom_range(0, 3) == 0) begin
				queue_advances(1);
			end
		end
		drain_block();
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_write    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		item.valid   = 1'b0;
		item.data    = '0;
		result.ready = 1'b0;
		send_gap     = 0;
		send_calm    = 0;
		stall_left   = 0;
		ready_calm   = 0;
		mismatches   = 0;
		pairs_checked    = 0;
		frames_predicted = 0;
		starts_taken     = 0;
		writes_done      = 0;
		phases_run       = 0;
		random_items     = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// register defaults: advance with no note, one-frame note, advance after it
		queue_advances(1);
		queue_item(OP_START, 0);
		queue_advances(2);
		drain_block();

		// extreme bases, depths and scales, both offset extremes, restart mid-note
		write_reg(CFG_BASE_AMPLITUDES, CFG_DATA_W'(16'hff00));
		write_reg(CFG_BASE_DURATIONS, CFG_DATA_W'(16'h00ff));
		write_reg(CFG_TREMOLO_DEPTHS, CFG_DATA_W'(16'hffff));
		write_reg(CFG_EXTRA_SCALES, {CFG_DATA_W{1'b1}});
		write_reg(CFG_RISE_STEPS, CFG_DATA_W'(1));
		write_reg(CFG_PLATEAU_STEPS, CFG_DATA_W'(3));
		write_reg(CFG_TREMOLO_QUARTER, CFG_DATA_W'(1));
		queue_item(OP_START, -128);
		queue_advances(4);
		queue_item(OP_START, 127);
		queue_advances(2);
		queue_item(OP_START, 0);
		queue_advances(1);
		drain_block();

		// no rise or fall frames, zero tremolo quarter
		write_reg(CFG_TREMOLO_DEPTHS, CFG_DATA_W'(16'h0a05));
		write_reg(CFG_EXTRA_SCALES, '0);
		write_reg(CFG_RISE_STEPS, CFG_DATA_W'(0));
		write_reg(CFG_PLATEAU_STEPS, CFG_DATA_W'(2));
		write_reg(CFG_TREMOLO_QUARTER, CFG_DATA_W'(0));
		queue_item(OP_START, 5);
		queue_advances(3);
		drain_block();

		// all frame counts zero: start leaves the block idle
		write_reg(CFG_PLATEAU_STEPS, CFG_DATA_W'(0));
		queue_item(OP_START, -1);
		queue_advances(1);
		drain_block();

		// rise count beyond the step table, widest plateau and quarter
		write_reg(CFG_BASE_AMPLITUDES, CFG_DATA_W'(16'h00ff));
		write_reg(CFG_RISE_STEPS, CFG_DATA_W'(255));
		write_reg(CFG_PLATEAU_STEPS, CFG_DATA_W'(1023));
		write_reg(CFG_TREMOLO_QUARTER, CFG_DATA_W'(255));
		queue_item(OP_START, 1);
		queue_advances(2);
		drain_block();

		write_reg(CFG_RISE_STEPS, CFG_DATA_W'(0));
		queue_item(OP_START, -2);
		queue_advances(2);
		drain_block();

		while (random_items < RANDOM_ITEMS) begin
			random_phase();
		end

		if (pairs_due.size() != 0) begin
			report_mismatch("pairs never delivered", 0, pairs_due.size());
		end
		$display("covered %0d phases with %0d register writes and %0d notes started",
			phases_run, writes_done, starts_taken);
		$display("compared %0d pairs from %0d frames, %0d mismatches",
			pairs_checked, frames_predicted, mismatches);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("timeout after %0d ns", RUN_LIMIT_NS);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
